[rtl/core/websocket_frame_deframer_top_macros.svh]
// Assertion macros shared by the frame deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/wsd_pkg.sv]
// Shared types and codes for the frame deframer.
package wsd_pkg;

  localparam logic [1:0] KIND_HEADER   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
  localparam logic [1:0] KIND_UNMASKED = 2'd2;
  localparam logic [1:0] KIND_TOO_LONG = 2'd3;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [31:0] MAX_LEN_RESET = 32'd65535;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [3:0]  opcode;
    logic        fin;
    logic [31:0] length;
    logic        last;
  } wsd_res_t;

endpackage

[rtl/core/wsd_parser.sv]
// Header parser and payload unmasker: holds the frame state, one byte per accepted transaction.
module wsd_parser import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_fire,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] max_len,
  output logic        res_fire,
  output wsd_res_t    res
);

  typedef enum logic [2:0] {
    PH_BYTE0   = 3'd0,
    PH_BYTE1   = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] idx_r, idx_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        fin_r, fin_nxt;

  logic [63:0] len_chk;
  logic        too_long;
  logic [31:0] len_sat;
  logic [7:0]  key_byte;
  logic        last_byte;

  // Candidate length for the check: the 7-bit field, or one more extended byte.
  assign len_chk  = (phase_r == PH_BYTE1) ? {57'd0, rx_byte[6:0]} : {acc_r[55:0], rx_byte};
  assign too_long = (len_chk[63:32] != 32'd0) || (len_chk[31:0] > max_len);
  assign len_sat  = (len_chk[63:32] != 32'd0) ? 32'hFFFF_FFFF : len_chk[31:0];

  // The first key byte on the wire sits in the top byte of the key register.
  always_comb begin
    case (idx_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign last_byte = ({1'b0, idx_r} + 33'd1) >= {1'b0, acc_r[31:0]};

  always_comb begin
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    acc_nxt    = acc_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    opcode_nxt = opcode_r;
    fin_nxt    = fin_r;
    res_fire   = 1'b0;
    res        = '{kind: KIND_HEADER, payload_byte: 8'd0, opcode: opcode_r, fin: fin_r,
                   length: 32'd0, last: 1'b0};
    unique case (phase_r)
      PH_BYTE1: begin
        acc_nxt = 64'd0;
        if (!rx_byte[7]) begin
          res_fire    = 1'b1;
          res.kind    = KIND_UNMASKED;
          res.last    = 1'b1;
          phase_nxt   = PH_BYTE0;
        end else begin
          hcnt_nxt = 3'd0;
          if (rx_byte[6:0] == LEN7_EXT16) begin
            phase_nxt = PH_EXT16;
          end else if (rx_byte[6:0] == LEN7_EXT64) begin
            phase_nxt = PH_EXT64;
          end else begin
            acc_nxt = len_chk;
            if (too_long) begin
              res_fire   = 1'b1;
              res.kind   = KIND_TOO_LONG;
              res.length = len_sat;
              res.last   = 1'b1;
              phase_nxt  = PH_BYTE0;
            end else begin
              phase_nxt = PH_KEY;
            end
          end
        end
      end
      PH_EXT16, PH_EXT64: begin
        acc_nxt = len_chk;
        if ((phase_r == PH_EXT16 && hcnt_r == 3'd1) || (phase_r == PH_EXT64 && hcnt_r == 3'd7))
        begin
          if (too_long) begin
            res_fire   = 1'b1;
            res.kind   = KIND_TOO_LONG;
            res.length = len_sat;
            res.last   = 1'b1;
            phase_nxt  = PH_BYTE0;
          end else begin
            hcnt_nxt  = 3'd0;
            phase_nxt = PH_KEY;
          end
        end else begin
          hcnt_nxt = hcnt_r + 3'd1;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], rx_byte};
        if (hcnt_r < 3'd3) begin
          hcnt_nxt = hcnt_r + 3'd1;
        end else begin
          idx_nxt    = 32'd0;
          res_fire   = 1'b1;
          res.kind   = KIND_HEADER;
          res.length = acc_r[31:0];
          if (acc_r == 64'd0) begin
            res.last  = 1'b1;
            phase_nxt = PH_BYTE0;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_fire         = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = rx_byte ^ key_byte;
        res.length       = acc_r[31:0];
        res.last         = last_byte;
        idx_nxt          = idx_r + 32'd1;
        if (last_byte) begin
          phase_nxt = PH_BYTE0;
        end
      end
      default: begin
        opcode_nxt = rx_byte[3:0];
        fin_nxt    = rx_byte[7];
        phase_nxt  = PH_BYTE1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_BYTE0;
      hcnt_r   <= 3'd0;
      acc_r    <= 64'd0;
      key_r    <= 32'd0;
      idx_r    <= 32'd0;
      opcode_r <= 4'd0;
      fin_r    <= 1'b0;
    end else if (byte_fire) begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      acc_r    <= acc_nxt;
      key_r    <= key_nxt;
      idx_r    <= idx_nxt;
      opcode_r <= opcode_nxt;
      fin_r    <= fin_nxt;
    end
  end

endmodule

[rtl/core/websocket_frame_deframer_top.sv]
// Top level of the frame deframer: config register, parser and two-entry result buffer.
//
// The input channel (in_valid/in_ready/in_rx_byte) takes one frame byte per transaction,
// in wire order. The output channel (out_valid/out_ready/out_*) gives zero or one result
// per byte: a header result once the masking key is complete, one result per payload
// byte with the key applied, or an error result that ends the frame.
// A result enters the buffer at the edge at which its byte is taken and is shown on
// out_valid from the main entry. Throughput is one byte per cycle while in_ready is high,
// set by the single register stage of the parser state and the result register after it.
// The result side is a main register plus a skid register, so in_ready depends only on
// local state. When the receiver stalls, one further result is still held in the skid
// entry, and bytes that give no result keep being taken; in_ready drops once both
// entries hold results and rises again when one is taken.
// cfg_wr_en/cfg_wr_data write the maximum payload length, with no wait; write it only
// while the block is idle. Reset (rst_n low, synchronous) empties the buffer, returns
// the parser to waiting for the first header byte and sets the maximum to 65535.
module websocket_frame_deframer_top import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic [3:0]  out_frame_opcode,
  output logic        out_final_fragment,
  output logic [31:0] out_payload_length,
  output logic        out_last_of_frame,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

`include "websocket_frame_deframer_top_macros.svh"

  logic [31:0] max_len_r;
  logic        main_valid_r;
  logic        skid_valid_r;
  wsd_res_t    main_r;
  wsd_res_t    skid_r;
  wsd_res_t    res;
  logic        res_fire;
  logic        in_fire;
  logic        push;
  logic        pop;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign push     = in_fire && res_fire;
  assign pop      = main_valid_r && out_ready;

  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (in_fire),
    .rx_byte   (in_rx_byte),
    .max_len   (max_len_r),
    .res_fire  (res_fire),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      if (main_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end
  end

  // Payload side of the buffer; the valid bits above qualify it.
  always_ff @(posedge clk) begin
    if (pop && skid_valid_r) begin
      main_r <= skid_r;
    end else if (push && (pop || !main_valid_r)) begin
      main_r <= res;
    end
    if (push && main_valid_r && !pop) begin
      skid_r <= res;
    end
  end

  assign out_valid          = main_valid_r;
  assign out_result_kind    = main_r.kind;
  assign out_payload_byte   = main_r.payload_byte;
  assign out_frame_opcode   = main_r.opcode;
  assign out_final_fragment = main_r.fin;
  assign out_payload_length = main_r.length;
  assign out_last_of_frame  = main_r.last;

  `WSD_ASSERT_NOW(a_skid_behind_main, skid_valid_r, main_valid_r,
    "skid entry held while main entry is empty")
  `WSD_ASSERT_NOW(a_error_ends_frame,
    out_valid && (out_result_kind == KIND_UNMASKED || out_result_kind == KIND_TOO_LONG),
    out_last_of_frame, "error result does not end the frame")
  `WSD_ASSERT_NOW(a_byte_only_payload, out_valid && out_result_kind != KIND_PAYLOAD,
    out_payload_byte == 8'd0, "nonzero data byte on a non-payload result")
  `WSD_ASSERT_NEXT(a_stall_fills_skid,
    main_valid_r && !out_ready && !skid_valid_r && push, skid_valid_r && main_valid_r,
    "result accepted under a stall was not held in the skid entry")

endmodule
